// ----- rtl/core/multi_pipe_fifo_table_defines.svh -----
// Assertion macros for the multi-pipe FIFO table.
// Included by the top level; no other dependencies.
`ifndef MULTI_PIPE_FIFO_TABLE_DEFINES_SVH
`define MULTI_PIPE_FIFO_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset
`define MPFT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// Check that a condition is followed by a consequence in the next cycle
`define MPFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPFT_ASSERT(label, clk, rst, prop, msg)
`define MPFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/mpft_pkg.sv -----
// Shared types and constants of the multi-pipe FIFO table.
// No dependencies; used by the interfaces and all modules but mpft_ram.
`timescale 1ns / 1ps
package mpft_pkg;

  localparam int DESC_W     = 16;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int BYTE_W     = 8;
  localparam int SLOT_OUT_W = 4;

  localparam logic [DESC_W-1:0] FIRST_DESC     = 16'd3;
  localparam logic [DESC_W-1:0] LAST_GOOD_DESC = 16'hFFFD;
  localparam logic [BYTE_W-1:0] END_MARK       = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE  = 3'd0,
    MODE_WRITE   = 3'd1,
    MODE_READ    = 3'd2,
    MODE_EOF     = 3'd3,
    MODE_DESTROY = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BADFD   = 3'd1,
    ST_NOSLOT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_EXHAUST = 3'd5
  } status_t;

  // Update of the slot valid bits
  typedef struct packed {
    logic set_en;
    logic clr_en;
  } alloc_ctl_t;

endpackage

// ----- rtl/core/mpft_in_if.sv -----
// Request channel of the multi-pipe FIFO table.
// Depends on mpft_pkg for field widths.
`timescale 1ns / 1ps
interface mpft_in_if;
  logic                            valid;
  logic                            ready;
  logic [mpft_pkg::MODE_W-1:0]     mode;
  logic [mpft_pkg::DESC_W-1:0]     fd;
  logic [mpft_pkg::BYTE_W-1:0]     data_in;
  logic                            last;

  modport source (output valid, mode, fd, data_in, last, input ready);
  modport sink   (input valid, mode, fd, data_in, last, output ready);
endinterface

// ----- rtl/core/mpft_out_if.sv -----
// Result channel of the multi-pipe FIFO table.
// Depends on mpft_pkg for field widths.
`timescale 1ns / 1ps
interface mpft_out_if;
  logic                              valid;
  logic                              ready;
  logic [mpft_pkg::STATUS_W-1:0]     status;
  logic [mpft_pkg::BYTE_W-1:0]       data_out;
  logic [mpft_pkg::DESC_W-1:0]       read_fd;
  logic [mpft_pkg::DESC_W-1:0]       write_fd;
  logic [mpft_pkg::SLOT_OUT_W-1:0]   slot;
  logic                              last_out;

  modport source (output valid, status, data_out, read_fd, write_fd, slot, last_out,
                  input ready);
  modport sink   (input valid, status, data_out, read_fd, write_fd, slot, last_out,
                  output ready);
endinterface

// ----- rtl/core/mpft_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module mpft_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/core/mpft_alloc.sv -----
// Slot valid bits and registered lowest-free-slot encoder.
// Depends on mpft_pkg for the control struct.
`timescale 1ns / 1ps
module mpft_alloc #(
  parameter int NUM_PIPES = 16,
  parameter int SLOT_W    = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mpft_pkg::alloc_ctl_t ctl,
  input  logic [SLOT_W-1:0]    idx,
  input  logic [SLOT_W-1:0]    query_idx,
  output logic                 query_valid,
  output logic [SLOT_W-1:0]    free_idx,
  output logic                 has_free
);
  logic [NUM_PIPES-1:0] valid_bits;
  logic [SLOT_W-1:0]    enc_idx;
  logic                 enc_found;

  // Set on create, clear on destroy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else begin
      if (ctl.set_en) begin
        valid_bits[idx] <= 1'b1;
      end
      if (ctl.clr_en) begin
        valid_bits[idx] <= 1'b0;
      end
    end
  end

  // Find the lowest free slot
  always_comb begin
    enc_idx   = '0;
    enc_found = 1'b0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        enc_idx   = SLOT_W'(i);
        enc_found = 1'b1;
      end
    end
  end

  // Hold the encoder result for the next create
  always_ff @(posedge clk) begin
    if (rst) begin
      free_idx <= '0;
      has_free <= 1'b1;
    end else begin
      free_idx <= enc_idx;
      has_free <= enc_found;
    end
  end

  assign query_valid = valid_bits[query_idx];
endmodule

// ----- rtl/core/multi_pipe_fifo_table.sv -----
// Multi-pipe FIFO table: byte ring-buffer pipes named by descriptor pairs.
// An item steps through the slot, action and output states, reading the descriptor map,
// slot table and byte store in turn; a new item waits until its result is registered.
// Reset clears the slot valid bits, sets the descriptor counter to 3 and idles control;
// the memories are not cleared and need no clearing pass.
// Depends on mpft_pkg, mpft_in_if, mpft_out_if, mpft_ram, mpft_alloc and the defines header.
`timescale 1ns / 1ps
`include "multi_pipe_fifo_table_defines.svh"
module multi_pipe_fifo_table #(
  parameter int NUM_PIPES  = 16,
  parameter int PIPE_DEPTH = 512
) (
  input  logic       clk,
  input  logic       rst,
  mpft_in_if.sink    req,
  mpft_out_if.source rsp
);
  localparam int DESC_W = mpft_pkg::DESC_W;
  localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int PTR_W  = $clog2(PIPE_DEPTH);
  localparam int CNT_W  = $clog2(PIPE_DEPTH + 1);
  localparam int MAP_AW = DESC_W - 1;
  localparam int ST_W   = DESC_W + 2 * PTR_W + CNT_W;
  localparam int BS_AW  = SLOT_W + PTR_W;

  typedef enum logic [1:0] {S_IDLE, S_SLOT, S_ACT, S_OUT} state_t;

  state_t state;

  // Item held while it is worked on
  logic [mpft_pkg::MODE_W-1:0] cur_mode;
  logic [DESC_W-1:0]           cur_rd;
  logic                        cur_fd_ok;
  logic [mpft_pkg::BYTE_W-1:0] cur_din;
  logic                        cur_last;
  logic [SLOT_W-1:0]           s_idx;

  logic [DESC_W-1:0]           next_desc;
  logic [DESC_W-1:0]           in_rd;
  logic                        in_is_read;
  logic                        accept;

  // Memory ports
  logic [MAP_AW-1:0]   map_raddr;
  logic [SLOT_W-1:0]   map_rdata;
  logic                map_we;
  logic [SLOT_W-1:0]   st_raddr;
  logic [ST_W-1:0]     st_rdata;
  logic                st_we;
  logic [ST_W-1:0]     st_wdata;
  logic [BS_AW-1:0]    bs_addr;
  logic                byte_we;
  logic                byte_re;
  logic [mpft_pkg::BYTE_W-1:0] byte_wdata;
  logic [mpft_pkg::BYTE_W-1:0] byte_rdata;

  // Slot allocator
  mpft_pkg::alloc_ctl_t alloc_ctl;
  logic                 query_valid;
  logic [SLOT_W-1:0]    free_idx;
  logic                 has_free;

  // Slot table fields
  logic [DESC_W-1:0] st_rdesc;
  logic [PTR_W-1:0]  st_head;
  logic [PTR_W-1:0]  st_tail;
  logic [CNT_W-1:0]  st_cnt;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail_inc;
  logic              hit;

  // Result of the action cycle
  mpft_pkg::status_t  act_status;
  logic               act_slot_ok;
  logic               act_pop;
  logic [DESC_W-1:0]  act_rfd;
  logic [DESC_W-1:0]  act_wfd;
  logic               desc_adv;

  mpft_pkg::status_t  res_status;
  logic               res_pop;
  logic [DESC_W-1:0]  res_rfd;
  logic [DESC_W-1:0]  res_wfd;
  logic [3:0]         res_slot;

  // Output register
  logic                          out_valid;
  logic [mpft_pkg::STATUS_W-1:0] out_status;
  logic [mpft_pkg::BYTE_W-1:0]   out_data;
  logic [DESC_W-1:0]             out_rfd;
  logic [DESC_W-1:0]             out_wfd;
  logic [3:0]                    out_slot;
  logic                          out_last;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Map the request descriptor onto the read descriptor of its pair
  assign in_is_read = (req.mode == mpft_pkg::MODE_READ);
  assign in_rd      = in_is_read ? req.fd : req.fd - 16'd1;
  assign map_raddr  = in_rd[DESC_W-1:1];

  assign st_raddr = (cur_mode == mpft_pkg::MODE_CREATE) ? free_idx : map_rdata;

  assign st_rdesc = st_rdata[ST_W-1 -: DESC_W];
  assign st_head  = st_rdata[2*PTR_W+CNT_W-1 -: PTR_W];
  assign st_tail  = st_rdata[PTR_W+CNT_W-1 -: PTR_W];
  assign st_cnt   = st_rdata[CNT_W-1:0];
  assign head_inc = (st_head == PTR_W'(PIPE_DEPTH - 1)) ? '0 : st_head + 1'b1;
  assign tail_inc = (st_tail == PTR_W'(PIPE_DEPTH - 1)) ? '0 : st_tail + 1'b1;
  assign hit      = cur_fd_ok && query_valid && (st_rdesc == cur_rd);

  // Descriptor map: read descriptor pair -> slot
  mpft_ram #(.WIDTH(SLOT_W), .AW(MAP_AW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (next_desc[DESC_W-1:1]),
    .wdata (s_idx),
    .re    (accept),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Slot table: descriptor, head, tail, fill count
  mpft_ram #(.WIDTH(ST_W), .AW(SLOT_W)) u_slot_tab (
    .clk   (clk),
    .we    (st_we),
    .waddr (s_idx),
    .wdata (st_wdata),
    .re    (state == S_SLOT),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Byte store: one ring of PIPE_DEPTH bytes per slot, in 2**PTR_W locations
  mpft_ram #(.WIDTH(mpft_pkg::BYTE_W), .AW(BS_AW)) u_byte_store (
    .clk   (clk),
    .we    (byte_we),
    .waddr (bs_addr),
    .wdata (byte_wdata),
    .re    (byte_re),
    .raddr (bs_addr),
    .rdata (byte_rdata)
  );

  mpft_alloc #(.NUM_PIPES(NUM_PIPES), .SLOT_W(SLOT_W)) u_alloc (
    .clk         (clk),
    .rst         (rst),
    .ctl         (alloc_ctl),
    .idx         (s_idx),
    .query_idx   (s_idx),
    .query_valid (query_valid),
    .free_idx    (free_idx),
    .has_free    (has_free)
  );

  // Decide the operation and its writes in the action cycle
  always_comb begin
    act_status  = mpft_pkg::ST_BADFD;
    act_slot_ok = 1'b0;
    act_pop     = 1'b0;
    act_rfd     = '0;
    act_wfd     = '0;
    desc_adv    = 1'b0;
    st_we       = 1'b0;
    st_wdata    = st_rdata;
    map_we      = 1'b0;
    byte_we     = 1'b0;
    byte_re     = 1'b0;
    byte_wdata  = cur_din;
    bs_addr     = {s_idx, st_tail};
    alloc_ctl   = '0;
    if (state == S_ACT) begin
      case (cur_mode)
        mpft_pkg::MODE_CREATE: begin
          if (!has_free) begin
            act_status = mpft_pkg::ST_NOSLOT;
          end else if (next_desc > mpft_pkg::LAST_GOOD_DESC) begin
            act_status = mpft_pkg::ST_EXHAUST;
          end else begin
            act_status       = mpft_pkg::ST_OK;
            act_slot_ok      = 1'b1;
            act_rfd          = next_desc;
            act_wfd          = next_desc + 16'd1;
            desc_adv         = 1'b1;
            st_we            = 1'b1;
            st_wdata         = {next_desc, {(2 * PTR_W + CNT_W){1'b0}}};
            map_we           = 1'b1;
            alloc_ctl.set_en = 1'b1;
          end
        end
        mpft_pkg::MODE_WRITE, mpft_pkg::MODE_EOF: begin
          if (hit) begin
            act_slot_ok = 1'b1;
            if (st_cnt == CNT_W'(PIPE_DEPTH)) begin
              act_status = mpft_pkg::ST_FULL;
            end else begin
              act_status = mpft_pkg::ST_OK;
              byte_we    = 1'b1;
              if (cur_mode == mpft_pkg::MODE_EOF) begin
                byte_wdata = mpft_pkg::END_MARK;
              end
              st_we    = 1'b1;
              st_wdata = {st_rdesc, st_head, tail_inc, st_cnt + 1'b1};
            end
          end
        end
        mpft_pkg::MODE_READ: begin
          if (hit) begin
            act_slot_ok = 1'b1;
            if (st_cnt == '0) begin
              act_status = mpft_pkg::ST_EMPTY;
            end else begin
              act_status = mpft_pkg::ST_OK;
              act_pop    = 1'b1;
              byte_re    = 1'b1;
              bs_addr    = {s_idx, st_head};
              st_we      = 1'b1;
              st_wdata   = {st_rdesc, head_inc, st_tail, st_cnt - 1'b1};
            end
          end
        end
        mpft_pkg::MODE_DESTROY: begin
          if (hit) begin
            act_status       = mpft_pkg::ST_OK;
            act_slot_ok      = 1'b1;
            alloc_ctl.clr_en = 1'b1;
          end
        end
        default: begin
          act_status = mpft_pkg::ST_BADFD;
        end
      endcase
    end
  end

  // Sequence one item through map, slot table and byte store
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      next_desc <= mpft_pkg::FIRST_DESC;
    end else begin
      // Drop the taken result unless the next one loads in the same cycle
      if (rsp.valid && rsp.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (desc_adv) begin
        next_desc <= next_desc + 16'd2;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_mode  <= req.mode;
            cur_rd    <= in_rd;
            cur_fd_ok <= (req.fd >= mpft_pkg::FIRST_DESC) && (req.fd < next_desc) &&
                         (req.fd[0] == in_is_read);
            cur_din   <= req.data_in;
            cur_last  <= req.last;
            state     <= S_SLOT;
          end
        end
        S_SLOT: begin
          s_idx <= st_raddr;
          state <= S_ACT;
        end
        S_ACT: begin
          res_status <= act_status;
          res_pop    <= act_pop;
          res_rfd    <= act_rfd;
          res_wfd    <= act_wfd;
          res_slot   <= act_slot_ok ? 4'(s_idx) : 4'd0;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_data   <= res_pop ? byte_rdata : '0;
            out_rfd    <= res_rfd;
            out_wfd    <= res_wfd;
            out_slot   <= res_slot;
            out_last   <= cur_last;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.data_out = out_data;
  assign rsp.read_fd  = out_rfd;
  assign rsp.write_fd = out_wfd;
  assign rsp.slot     = out_slot;
  assign rsp.last_out = out_last;

  // Descriptors are handed out in odd/even pairs
  `MPFT_ASSERT(a_desc_odd, clk, rst, next_desc[0], "descriptor counter lost pair alignment")
  // A successful create advances the counter by one pair
  `MPFT_ASSERT_NEXT(a_desc_step, clk, rst, desc_adv, next_desc == $past(next_desc) + 16'd2, "descriptor counter step wrong")
  // A fill count written back never passes the pipe depth
  `MPFT_ASSERT(a_cnt_bound, clk, rst, st_we |-> (st_wdata[CNT_W-1:0] <= CNT_W'(PIPE_DEPTH)), "fill count above pipe depth")
  // A pop only reads a pipe that holds data
  `MPFT_ASSERT(a_pop_nonempty, clk, rst, byte_re |-> (st_cnt != '0), "pop from an empty pipe")
endmodule

// ----- tb/tb_multi_pipe_fifo_table.sv -----
// Self-checking regression bench for the multi-pipe FIFO table.
// Uses mpft_pkg, the mpft_in_if / mpft_out_if channels and multi_pipe_fifo_table.
// Predicts every result from an in-bench model of the pipe table and descriptor counter.
`timescale 1ns / 1ps
module tb_multi_pipe_fifo_table;
  import mpft_pkg::*;

  localparam int NUM_PIPES      = 16;
  localparam int PIPE_DEPTH     = 512;
  localparam int RANDOM_PER_PAT = 64;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS    = 60;

  // How the driver picks the descriptor of an item when it goes on the bus
  typedef enum logic [1:0] {
    AIM_AS_IS,
    AIM_LIVE,
    AIM_STALE,
    AIM_NEWEST
  } fd_aim_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_pat_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DESC_W-1:0] fd;
    logic [BYTE_W-1:0] data;
    logic              last;
    fd_aim_t           aim;
  } pipe_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [BYTE_W-1:0]     data;
    logic [DESC_W-1:0]     rfd;
    logic [DESC_W-1:0]     wfd;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  last;
  } pipe_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              req_valid = 1'b0;
  logic [MODE_W-1:0] req_mode  = '0;
  logic [DESC_W-1:0] req_fd    = '0;
  logic [BYTE_W-1:0] req_data  = '0;
  logic              req_last  = 1'b0;
  logic              rsp_ready = 1'b0;

  mpft_in_if  req_if ();
  mpft_out_if rsp_if ();

  assign req_if.valid   = req_valid;
  assign req_if.mode    = req_mode;
  assign req_if.fd      = req_fd;
  assign req_if.data_in = req_data;
  assign req_if.last    = req_last;
  assign rsp_if.ready   = rsp_ready;

  multi_pipe_fifo_table #(
    .NUM_PIPES (NUM_PIPES),
    .PIPE_DEPTH(PIPE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Model of the pipe table
  bit          pipe_live  [NUM_PIPES];
  logic [16:0] pipe_rdesc [NUM_PIPES];
  int          pipe_head  [NUM_PIPES];
  int          pipe_tail  [NUM_PIPES];
  int          pipe_fill  [NUM_PIPES];
  logic [7:0]  pipe_bytes [NUM_PIPES*PIPE_DEPTH];
  logic [16:0] desc_next;

  pipe_cmd_t    cmd_q[$];
  pipe_result_t result_q[$];
  pipe_cmd_t    cur_cmd;
  pipe_result_t want;

  idle_pat_t idle_mode  = IDLE_NONE;
  bit        hold_armed = 1'b0;
  int        hold_left  = 0;

  int n_accepted = 0;
  int n_checked  = 0;
  int n_fail     = 0;
  int status_seen [8];

  // Clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #(40_000_000);
    $display("multi_pipe_fifo_table regression: fail");
    $finish;
  end

  function automatic int find_pipe(logic [DESC_W-1:0] fd, bit write_side);
    int i;
    if (fd < FIRST_DESC || {1'b0, fd} >= desc_next) return -1;
    for (i = 0; i < NUM_PIPES; i++) begin
      if (pipe_live[i] && pipe_rdesc[i] + write_side == {1'b0, fd}) return i;
    end
    return -1;
  endfunction

  function automatic int count_live();
    int i;
    int n;
    n = 0;
    for (i = 0; i < NUM_PIPES; i++) n += pipe_live[i];
    return n;
  endfunction

  // Apply one item to the model and return its result
  function automatic pipe_result_t run_pipe_op(pipe_cmd_t c);
    pipe_result_t r;
    int s;
    int i;
    r.status = ST_BADFD;
    r.data   = '0;
    r.rfd    = '0;
    r.wfd    = '0;
    r.slot   = '0;
    r.last   = c.last;
    case (c.mode)
      MODE_CREATE: begin
        s = -1;
        for (i = NUM_PIPES - 1; i >= 0; i--) begin
          if (!pipe_live[i]) s = i;
        end
        if (s < 0) begin
          r.status = ST_NOSLOT;
        end else if (desc_next > LAST_GOOD_DESC) begin
          r.status = ST_EXHAUST;
        end else begin
          pipe_live[s]  = 1'b1;
          pipe_rdesc[s] = desc_next;
          pipe_head[s]  = 0;
          pipe_tail[s]  = 0;
          pipe_fill[s]  = 0;
          r.rfd     = desc_next[DESC_W-1:0];
          r.wfd     = desc_next[DESC_W-1:0] + 1'b1;
          r.slot    = SLOT_OUT_W'(s);
          r.status  = ST_OK;
          desc_next = desc_next + 17'd2;
        end
      end
      MODE_WRITE, MODE_EOF: begin
        s = find_pipe(c.fd, 1'b1);
        if (s >= 0) begin
          r.slot = SLOT_OUT_W'(s);
          if (pipe_fill[s] >= PIPE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            pipe_bytes[s*PIPE_DEPTH + pipe_tail[s]] = (c.mode == MODE_WRITE) ? c.data : END_MARK;
            pipe_tail[s] = (pipe_tail[s] + 1) % PIPE_DEPTH;
            pipe_fill[s]++;
            r.status = ST_OK;
          end
        end
      end
      MODE_READ: begin
        s = find_pipe(c.fd, 1'b0);
        if (s >= 0) begin
          r.slot = SLOT_OUT_W'(s);
          if (pipe_fill[s] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = pipe_bytes[s*PIPE_DEPTH + pipe_head[s]];
            pipe_head[s] = (pipe_head[s] + 1) % PIPE_DEPTH;
            pipe_fill[s]--;
            r.status = ST_OK;
          end
        end
      end
      MODE_DESTROY: begin
        s = find_pipe(c.fd, 1'b1);
        if (s >= 0) begin
          pipe_live[s] = 1'b0;
          r.slot   = SLOT_OUT_W'(s);
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Pick the descriptor for an item from the model state at issue time
  function automatic logic [DESC_W-1:0] aim_fd(pipe_cmd_t c);
    int          picks[$];
    int          i;
    int          s;
    logic [16:0] w;
    bit          rd_side;
    rd_side = (c.mode == MODE_READ);
    case (c.aim)
      AIM_LIVE: begin
        for (i = 0; i < NUM_PIPES; i++) begin
          if (pipe_live[i]) picks.push_back(i);
        end
        if (picks.size() == 0) return c.fd;
        s = picks[$urandom_range(0, picks.size() - 1)];
        w = pipe_rdesc[s] + !rd_side;
      end
      AIM_STALE:  w = 17'($urandom_range(0, int'(desc_next)));
      AIM_NEWEST: w = desc_next - (rd_side ? 17'd2 : 17'd1);
      default:    w = {1'b0, c.fd};
    endcase
    return w[DESC_W-1:0];
  endfunction

  function automatic bit idle_roll(bit sender_side);
    int pct;
    pct = 0;
    if (idle_mode == IDLE_BOTH) pct = 23;
    else if (sender_side && idle_mode == IDLE_SENDER) pct = 47;
    else if (!sender_side && idle_mode == IDLE_RECEIVER) pct = 47;
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic report_fail(string what, logic [31:0] exp_v, logic [31:0] act_v);
    n_fail++;
    if (n_fail <= MAX_REPORTS) $error("%s: expected 0x%0h, got 0x%0h", what, exp_v, act_v);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) report_fail(name, exp_v, act_v);
  endtask

  // Driver: predict on acceptance, then offer the next pending item
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      for (int i = 0; i < NUM_PIPES; i++) begin
        pipe_live[i] = 1'b0;
        pipe_rdesc[i] = '0;
        pipe_head[i] = 0;
        pipe_tail[i] = 0;
        pipe_fill[i] = 0;
      end
      desc_next = {1'b0, FIRST_DESC};
    end else begin
      if (req_valid && req_if.ready) begin
        result_q.push_back(run_pipe_op(cur_cmd));
        n_accepted++;
      end
      if (!req_valid || req_if.ready) begin
        if (cmd_q.size() != 0 && !idle_roll(1'b1)) begin
          cur_cmd    = cmd_q.pop_front();
          cur_cmd.fd = aim_fd(cur_cmd);
          req_valid <= 1'b1;
          req_mode  <= cur_cmd.mode;
          req_fd    <= cur_cmd.fd;
          req_data  <= cur_cmd.data;
          req_last  <= cur_cmd.last;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Count the long receiver hold-off in cycles
  always @(posedge clk) begin
    if (hold_armed && hold_left < RX_HOLD_CYCLES) begin
      hold_left <= hold_left + 1;
    end
  end

  // Monitor: compare each result with the oldest expectation, pace ready
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ready && rsp_if.valid) begin
        if (result_q.size() == 0) begin
          report_fail("result with no expectation, status", 32'hFFFF_FFFF, rsp_if.status);
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, rsp_if.status);
          check_field("data_out", want.data, rsp_if.data_out);
          check_field("read_fd", want.rfd, rsp_if.read_fd);
          check_field("write_fd", want.wfd, rsp_if.write_fd);
          check_field("slot", want.slot, rsp_if.slot);
          check_field("last_out", want.last, rsp_if.last_out);
          status_seen[want.status]++;
          n_checked++;
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (hold_armed && hold_left < RX_HOLD_CYCLES) begin
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !idle_roll(1'b0);
      end
    end
  end

  task automatic add_cmd(logic [MODE_W-1:0] mode, logic [DESC_W-1:0] fd,
                         logic [BYTE_W-1:0] data, logic last, fd_aim_t aim);
    pipe_cmd_t c;
    c.mode = mode;
    c.fd   = fd;
    c.data = data;
    c.last = last;
    c.aim  = aim;
    cmd_q.push_back(c);
  endtask

  // Mostly traffic on live pipes, the rest stale, random or unused-mode noise
  task automatic add_random_cmd();
    int                roll;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [DESC_W-1:0] rfd;
    roll = $urandom_range(0, 99);
    data = BYTE_W'($urandom);
    last = 1'($urandom);
    rfd  = DESC_W'($urandom);
    if (roll < 7) begin
      add_cmd(MODE_CREATE, rfd, data, last, AIM_AS_IS);
    end else if (roll < 42) begin
      add_cmd(($urandom_range(0, 7) == 0) ? MODE_EOF : MODE_WRITE, rfd, data, last, AIM_LIVE);
    end else if (roll < 78) begin
      add_cmd(MODE_READ, rfd, data, last, AIM_LIVE);
    end else if (roll < 83) begin
      add_cmd(MODE_DESTROY, rfd, data, last, AIM_LIVE);
    end else if (roll < 91) begin
      add_cmd(MODE_W'($urandom_range(MODE_WRITE, MODE_DESTROY)), rfd, data, last, AIM_STALE);
    end else if (roll < 96) begin
      add_cmd(MODE_W'($urandom_range(MODE_CREATE, MODE_DESTROY)), rfd, data, last, AIM_AS_IS);
    end else begin
      add_cmd(MODE_W'($urandom_range(int'(MODE_DESTROY) + 1, (1 << MODE_W) - 1)),
              rfd, data, last, AIM_AS_IS);
    end
  endtask

  // Sample on the falling edge, after every rising-edge update has settled
  task automatic wait_drained();
    while (cmd_q.size() != 0 || req_valid || result_q.size() != 0) @(negedge clk);
  endtask

  // Stimulus sequencing
  initial begin
    int s;
    int n;
    logic [DESC_W-1:0] wfd;
    logic [DESC_W-1:0] rfd;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: descriptor bounds, wrong side, end marker, empty, unused modes
    add_cmd(MODE_READ, 16'd0, 8'h00, 1'b0, AIM_AS_IS);
    add_cmd(MODE_WRITE, 16'd3, 8'h11, 1'b1, AIM_AS_IS);
    add_cmd(MODE_CREATE, 16'hFFFF, 8'hFF, 1'b1, AIM_AS_IS);
    add_cmd(MODE_WRITE, 16'd4, 8'h00, 1'b0, AIM_AS_IS);
    add_cmd(MODE_WRITE, 16'd4, 8'hFF, 1'b1, AIM_AS_IS);
    add_cmd(MODE_EOF, 16'd4, 8'h5A, 1'b0, AIM_AS_IS);
    add_cmd(MODE_WRITE, 16'd3, 8'h77, 1'b0, AIM_AS_IS);
    add_cmd(MODE_READ, 16'd4, 8'h00, 1'b1, AIM_AS_IS);
    for (int i = 0; i < 4; i++) add_cmd(MODE_READ, 16'd3, 8'h00, 1'(i), AIM_AS_IS);
    for (int m = int'(MODE_DESTROY) + 1; m < (1 << MODE_W); m++) begin
      add_cmd(MODE_W'(m), 16'd4, 8'hC3, 1'b1, AIM_AS_IS);
    end
    add_cmd(MODE_DESTROY, 16'd3, 8'h00, 1'b0, AIM_AS_IS);
    add_cmd(MODE_DESTROY, 16'd4, 8'h00, 1'b0, AIM_AS_IS);
    add_cmd(MODE_READ, 16'd3, 8'h00, 1'b0, AIM_AS_IS);
    add_cmd(MODE_CREATE, 16'd0, 8'h00, 1'b0, AIM_AS_IS);
    add_cmd(MODE_WRITE, 16'hFFFF, 8'hA5, 1'b1, AIM_AS_IS);
    add_cmd(MODE_CREATE, 16'd0, 8'h00, 1'b1, AIM_AS_IS);
    add_cmd(MODE_DESTROY, 16'd6, 8'h00, 1'b0, AIM_AS_IS);
    add_cmd(MODE_CREATE, 16'd0, 8'h00, 1'b0, AIM_AS_IS);
    add_cmd(MODE_WRITE, 16'd8, 8'hA5, 1'b1, AIM_AS_IS);
    wait_drained();

    // Fill the table past its end, then free most slots
    n = NUM_PIPES - count_live() + 1;
    for (int i = 0; i < n; i++) add_cmd(MODE_CREATE, 16'd0, 8'h00, 1'($urandom), AIM_AS_IS);
    for (int i = 0; i < 12; i++) add_cmd(MODE_DESTROY, 16'd0, 8'h00, 1'b0, AIM_LIVE);
    wait_drained();

    // Fill one pipe past full, then drain it past empty so both pointers wrap;
    // the receiver holds off meanwhile so the block backs up
    s = 0;
    while (!pipe_live[s]) s++;
    rfd = pipe_rdesc[s][DESC_W-1:0];
    wfd = rfd + 1'b1;
    n = PIPE_DEPTH - pipe_fill[s] + 2;
    for (int i = 0; i < n; i++) begin
      add_cmd(($urandom_range(0, 15) == 0) ? MODE_EOF : MODE_WRITE, wfd,
              BYTE_W'($urandom), 1'($urandom), AIM_AS_IS);
    end
    for (int i = 0; i < PIPE_DEPTH + 1; i++) begin
      add_cmd(MODE_READ, rfd, 8'h00, 1'($urandom), AIM_AS_IS);
    end
    hold_armed = 1'b1;
    wait_drained();

    // Random traffic under each idle pattern
    for (int p = 0; p < 4; p++) begin
      idle_mode = idle_pat_t'(p);
      for (int i = 0; i < RANDOM_PER_PAT; i++) add_random_cmd();
      wait_drained();
    end
    idle_mode = IDLE_NONE;

    // Newest pair, descriptors beyond the counter, free and retake a slot
    add_cmd(MODE_CREATE, 16'd0, 8'h00, 1'b1, AIM_AS_IS);
    add_cmd(MODE_WRITE, 16'd0, 8'h96, 1'b0, AIM_NEWEST);
    add_cmd(MODE_EOF, 16'd0, 8'h00, 1'b1, AIM_NEWEST);
    add_cmd(MODE_READ, 16'd0, 8'h00, 1'b0, AIM_NEWEST);
    add_cmd(MODE_READ, 16'd0, 8'h00, 1'b1, AIM_NEWEST);
    add_cmd(MODE_READ, 16'hFFFF, 8'h00, 1'b1, AIM_AS_IS);
    add_cmd(MODE_WRITE, 16'hFFFE, 8'h3C, 1'b0, AIM_AS_IS);
    add_cmd(MODE_DESTROY, 16'd0, 8'h00, 1'b0, AIM_LIVE);
    add_cmd(MODE_CREATE, 16'd0, 8'h00, 1'b1, AIM_AS_IS);
    wait_drained();
    repeat (12) @(posedge clk);

    $display("covered %0d items, %0d results: ok %0d, bad fd %0d, no slot %0d, full %0d,",
             n_accepted, n_checked, status_seen[ST_OK], status_seen[ST_BADFD],
             status_seen[ST_NOSLOT], status_seen[ST_FULL]);
    $display("  empty %0d, exhausted %0d; descriptor counter ended at 0x%0h",
             status_seen[ST_EMPTY], status_seen[ST_EXHAUST], desc_next);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("multi_pipe_fifo_table regression: pass");
    end else begin
      $display("multi_pipe_fifo_table regression: fail");
    end
    $finish;
  end

endmodule
